@@ sv/pulse_radius_generator_defines.svh @@
// Assertion macros used by the pulse radius generator controller.
`ifndef PULSE_RADIUS_GENERATOR_DEFINES_SVH
`define PULSE_RADIUS_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define PRG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define PRG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/prg_pkg.sv @@
// Package: widths, constants, codes and control types of the pulse radius generator.
`timescale 1ns / 1ps
package prg_pkg;

	localparam int ELAPSED_W  = 20;
	localparam int RADIUS_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int SAMPLE_W   = 16;   // sine table entry, Q0.16
	localparam int DIVISOR_W  = 26;   // period_ms * 1000 < 2^26
	localparam int FRAC_W     = 17;   // smoothstep value, Q16 up to 1.0

	localparam int DEF_SINE_DEPTH = 1024;
	localparam int DEF_PHASE_BITS = 32;

	localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [9:0]            US_PER_MS    = 10'd1000;

	// Sine table build, Q30 Taylor series on a quarter wave
	localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD = 2'd0,
		CFG_RMIN   = 2'd1,
		CFG_RMAX   = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_ACCUM,
		ST_INDEX,
		ST_ROM,
		ST_SQUARE,
		ST_SMOOTH,
		ST_BLEND
	} prg_state_t;

	typedef struct packed {
		logic load;
		logic clear_phase;
		logic div_init;
		logic div_step;
		logic accum;
		logic index;
		logic rom_read;
		logic square;
		logic smooth;
		logic blend;
	} prg_cmd_t;

	typedef struct packed {
		logic restart;
		logic period_zero;
	} prg_sts_t;

endpackage

@@ sv/prg_ifs.sv @@
// Valid/ready channel interfaces: tick input, radius output, register writes.
`timescale 1ns / 1ps

interface prg_tick_if;
	import prg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_us;
	logic                 restart;
	modport source (output valid, elapsed_us, restart, input ready);
	modport sink   (input valid, elapsed_us, restart, output ready);
endinterface

interface prg_radius_if;
	import prg_pkg::*;
	logic                valid;
	logic                ready;
	logic [RADIUS_W-1:0] radius;
	modport source (output valid, radius, input ready);
	modport sink   (input valid, radius, output ready);
endinterface

interface prg_cfg_if;
	import prg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/pulse_radius_generator.sv @@
// Pulse radius generator: the phase step comes from a restoring divider that yields
// one quotient bit per cycle.
// Restart ticks and ticks with period_ms zero skip the divider.
// One tick is in work at a time; the next is taken once the radius is
// registered, while that radius may still wait in the output register.
// arst_n clears control, phase to zero, period_ms to 1000 and both radius limits to zero.
`timescale 1ns / 1ps

module pulse_radius_generator import prg_pkg::*; #(
	parameter int SINE_DEPTH = DEF_SINE_DEPTH,
	parameter int PHASE_BITS = DEF_PHASE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	prg_tick_if.sink      tick,
	prg_radius_if.source  result,
	prg_cfg_if.sink       cfg
);

	prg_cmd_t cmd;
	prg_sts_t sts;

	assign cfg.ready = 1'b1;

	prg_ctrl #(
		.PHASE_BITS (PHASE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prg_datapath #(
		.SINE_DEPTH (SINE_DEPTH),
		.PHASE_BITS (PHASE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.elapsed_us (tick.elapsed_us),
		.restart    (tick.restart),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.radius     (result.radius)
	);

endmodule

@@ sv/prg_ctrl.sv @@
// Controller: tick sequencing, divider step count and output register valid.
`timescale 1ns / 1ps
`include "pulse_radius_generator_defines.svh"

module prg_ctrl import prg_pkg::*; #(
	parameter int PHASE_BITS = DEF_PHASE_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  prg_sts_t sts,
	output prg_cmd_t cmd
);

	localparam int DIV_STEPS = ELAPSED_W + PHASE_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	prg_state_t       state_q, state_d;
	logic [CNT_W-1:0] div_cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				div_cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.blend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.restart) begin
					cmd.clear_phase = 1'b1;
					state_d         = ST_INDEX;
				end else if (sts.period_zero) begin
					state_d = ST_INDEX;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_INDEX;
			end
			ST_INDEX: begin
				cmd.index = 1'b1;
				state_d   = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom_read = 1'b1;
				state_d      = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_BLEND;
			end
			ST_BLEND: begin
				// hold here until the output register has room for the beat
				if (out_free) begin
					cmd.blend = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PRG_ASSERT_NOW(a_out_after_blend, $rose(out_valid_q), $past(state_q) == ST_BLEND,
		"output valid rose without a blend step")
	`PRG_ASSERT_NOW(a_div_full_length, state_q == ST_ACCUM,
		$past(state_q) == ST_DIV && $past(div_cnt_q) == '0,
		"phase accumulated before the divider finished")
	`PRG_ASSERT_NOW(a_no_div_on_restart, state_q == ST_DIV, !sts.restart,
		"divider running on a restart tick")
	`PRG_ASSERT_NEXT(a_blend_to_out, state_q == ST_BLEND && out_free,
		out_valid_q && state_q == ST_IDLE, "blended radius not presented")

endmodule

@@ sv/prg_datapath.sv @@
// Datapath: config registers, phase divider and accumulator, sine ROM, smoothstep and blend.
`timescale 1ns / 1ps

module prg_datapath import prg_pkg::*; #(
	parameter int SINE_DEPTH = DEF_SINE_DEPTH,
	parameter int PHASE_BITS = DEF_PHASE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prg_cmd_t              cmd,
	output prg_sts_t              sts,
	input  logic [ELAPSED_W-1:0]  elapsed_us,
	input  logic                  restart,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [RADIUS_W-1:0]   radius
);

	localparam int IDX_W   = $clog2(SINE_DEPTH);
	localparam int DEPTH_W = $clog2(SINE_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_VAL = DEPTH_W'(SINE_DEPTH);
	localparam logic [63:0] DEPTH64 = 64'(SINE_DEPTH);

	typedef logic [SAMPLE_W-1:0] rom_t [SINE_DEPTH];

	// Entry k: round((1 + sin(2*pi*k/depth)) / 2 * 65536), capped at 65535
	function automatic logic [SAMPLE_W-1:0] rom_entry(input logic [63:0] k);
		logic [63:0] f32, quad, r, x, x2, acc, term, s, tq30, tq16;
		f32  = (k << 32) / DEPTH64;
		quad = (f32 >> 30) & 64'd3;
		r    = f32 & (Q30_ONE - 64'd1);
		if (quad[0]) begin
			r = Q30_ONE - r;
		end
		x   = (r * HALF_PI_Q30) >> 30;
		x2  = (x * x) >> 30;
		acc = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			term = ((x2 * acc) >> 30) / TAYLOR_DIV[i];
			acc  = (term > Q30_ONE) ? 64'd0 : Q30_ONE - term;
		end
		s = (x * acc) >> 30;
		if (quad >= 64'd2) begin
			tq30 = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
		end else begin
			tq30 = Q30_ONE + s;
		end
		tq16 = (tq30 + 64'd16384) >> 15;
		if (tq16 > 64'd65535) begin
			tq16 = 64'd65535;
		end
		return tq16[SAMPLE_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			rom[k] = rom_entry(64'(k));
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration and phase state
	logic [CFG_DATA_W-1:0] period_q, rmin_q, rmax_q;
	logic [PHASE_BITS-1:0] phase_q;

	// captured tick
	logic [ELAPSED_W-1:0] num_q;
	logic                 restart_q;

	// divider
	logic [DIVISOR_W-1:0]  divisor_q, rem_q, rem_next;
	logic [DIVISOR_W:0]    rem_ext;
	logic                  ge;
	logic [PHASE_BITS-1:0] quot_q;

	// lookup and easing
	logic [PHASE_BITS+DEPTH_W-1:0] idx_prod;
	logic [IDX_W-1:0]              idx_q;
	logic [SAMPLE_W-1:0]           t_q;
	logic [2*SAMPLE_W-1:0]         t2_q;
	logic [SAMPLE_W+1:0]           k_q;
	logic [3*SAMPLE_W+1:0]         smooth_prod;
	logic [3*SAMPLE_W+2:0]         smooth_sum;
	logic [FRAC_W-1:0]             f_q;

	// blend
	logic signed [CFG_DATA_W:0]   diff;
	logic signed [CFG_DATA_W+FRAC_W:0] blend_prod;
	logic signed [36:0]           blend_sum;
	logic signed [20:0]           blend_res;
	logic [RADIUS_W-1:0]          radius_q;

	assign sts.restart     = restart_q;
	assign sts.period_zero = (period_q == '0);
	assign radius          = radius_q;

	// restoring division, one quotient bit a cycle; elapsed bits first, then zeros
	assign rem_ext  = {rem_q, num_q[ELAPSED_W-1]};
	assign ge       = (rem_ext >= {1'b0, divisor_q});
	assign rem_next = ge ? DIVISOR_W'(rem_ext - {1'b0, divisor_q}) : rem_ext[DIVISOR_W-1:0];

	assign idx_prod = phase_q * DEPTH_VAL;

	assign smooth_prod = t2_q * k_q;
	assign smooth_sum  = {1'b0, smooth_prod} + (3*SAMPLE_W+3)'(64'h8000_0000);

	assign diff       = $signed({1'b0, rmax_q}) - $signed({1'b0, rmin_q});
	assign blend_prod = diff * $signed({1'b0, f_q});
	assign blend_sum  = $signed({5'b0, rmin_q, 16'b0}) + 37'(blend_prod) + 37'sd32768;
	assign blend_res  = blend_sum[36:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			rmin_q    <= '0;
			rmax_q    <= '0;
			phase_q   <= '0;
			restart_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PERIOD: period_q <= cfg_data;
					CFG_RMIN:   rmin_q   <= cfg_data;
					CFG_RMAX:   rmax_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				restart_q <= restart;
			end
			if (cmd.clear_phase) begin
				phase_q <= '0;
			end else if (cmd.accum) begin
				phase_q <= phase_q + quot_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= elapsed_us;
		end else if (cmd.div_step) begin
			num_q <= {num_q[ELAPSED_W-2:0], 1'b0};
		end
		if (cmd.div_init) begin
			divisor_q <= DIVISOR_W'(period_q) * DIVISOR_W'(US_PER_MS);
			rem_q     <= '0;
			quot_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[PHASE_BITS-2:0], ge};
		end
		if (cmd.index) begin
			idx_q <= idx_prod[PHASE_BITS +: IDX_W];
		end
		if (cmd.rom_read) begin
			t_q <= SINE_ROM[idx_q];
		end
		if (cmd.square) begin
			t2_q <= t_q * t_q;
			k_q  <= 18'd196608 - {1'b0, t_q, 1'b0};
		end
		if (cmd.smooth) begin
			f_q <= (smooth_sum[3*SAMPLE_W+2:32] > 19'd65536) ? 17'd65536
				: smooth_sum[48:32];
		end
		if (cmd.blend) begin
			if (blend_res < 0) begin
				radius_q <= '0;
			end else if (|blend_res[19:16]) begin
				radius_q <= '1;
			end else begin
				radius_q <= blend_res[15:0];
			end
		end
	end

endmodule
